>>> src/lac_pkg.sv
// Shared types and constants for the layer alpha compositor.
package lac_pkg;

	// Default channel precision in bits
	localparam int LAC_CHANNEL_BITS = 8;

	// Number of result beats the output buffer holds
	localparam int LAC_OUT_DEPTH = 8;

	// Control bits that travel with a layer sample down the pipeline
	typedef struct packed {
		logic valid;
		logic last;
	} lac_ctl_t;

	// One composited output pixel
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} lac_pix_t;

endpackage

>>> src/lac_cover.sv
// Coverage stage: tracks remaining coverage and picks the weight of each layer.
module lac_cover #(
	parameter int CB = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        layer_red,
	input  logic [7:0]        layer_green,
	input  logic [7:0]        layer_blue,
	input  logic [7:0]        layer_alpha,
	input  logic              layer_present,
	input  logic              last_layer,
	output lac_pkg::lac_ctl_t ctl_s1,
	output logic [CB-1:0]     cov_s1,
	output logic [CB-1:0]     red_s1,
	output logic [CB-1:0]     green_s1,
	output logic [CB-1:0]     blue_s1
);
	import lac_pkg::*;

	localparam logic [CB-1:0] CMAX = '1;

	logic [CB-1:0] cov_q;
	logic [CB-1:0] alpha_eff;
	logic [CB-1:0] cov_min;
	logic [CB-1:0] cov_use;

	// Force the background opaque, clamp to what is left, drop absent layers
	always_comb begin
		alpha_eff = last_layer ? CMAX : CB'(layer_alpha);
		cov_min   = (cov_q < alpha_eff) ? cov_q : alpha_eff;
		cov_use   = layer_present ? cov_min : '0;
	end

	// Advance remaining coverage; refill it when the pixel ends
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cov_q  <= CMAX;
			ctl_s1 <= '0;
		end else begin
			ctl_s1.valid <= accept;
			ctl_s1.last  <= last_layer;
			if (accept) begin
				cov_q <= last_layer ? CMAX : (cov_q - cov_use);
			end
		end
	end

	// Hold the layer weight and channels for the lanes
	always_ff @(posedge clk) begin
		if (accept) begin
			cov_s1   <= cov_use;
			red_s1   <= CB'(layer_red);
			green_s1 <= CB'(layer_green);
			blue_s1  <= CB'(layer_blue);
		end
	end

endmodule

>>> src/lac_lane.sv
// Channel lane: weights one channel, scales by 1/CMAX and accumulates the pixel sum.
module lac_lane #(
	parameter int CB = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  lac_pkg::lac_ctl_t ctl_s1,
	input  logic [CB-1:0]     cov_s1,
	input  logic [CB-1:0]     ch_s1,
	output lac_pkg::lac_ctl_t ctl_s3,
	output logic [CB-1:0]     res
);
	import lac_pkg::*;

	localparam int            PW   = 2 * CB;
	localparam logic [CB-1:0] CMAX = '1;

	lac_ctl_t      ctl_s2;
	logic [PW-1:0] prod_s2;
	logic [PW:0]   quot_w;
	logic [CB-1:0] quot_s3;
	logic [CB:0]   sum_w;
	logic [CB-1:0] sum_q;

	// Weight the channel by the layer coverage
	always_ff @(posedge clk) begin
		prod_s2 <= PW'(cov_s1) * PW'(ch_s1);
	end

	// Divide by 2^CB-1: exact for products up to CMAX squared
	always_comb begin
		quot_w = (PW + 1)'(prod_s2) + (PW + 1)'(prod_s2 >> CB) + (PW + 1)'(1);
	end

	always_ff @(posedge clk) begin
		quot_s3 <= quot_w[PW-1:CB];
	end

	// Advance the control bits alongside the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	// Add to the running sum, saturating at CMAX
	always_comb begin
		sum_w = {1'b0, sum_q} + {1'b0, quot_s3};
		res   = (sum_w > {1'b0, CMAX}) ? CMAX : sum_w[CB-1:0];
	end

	// Keep the sum; clear it when the background ends the pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (ctl_s3.valid) begin
			sum_q <= ctl_s3.last ? '0 : res;
		end
	end

endmodule

>>> src/lac_out.sv
// Merge stage: joins the lane results into pixel beats and buffers them for the receiver.
module lac_out #(
	parameter int DEPTH = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              reserve,
	input  logic              wr_en,
	input  lac_pkg::lac_pix_t wr_pix,
	input  logic              out_stall,
	output logic              full,
	output logic              out_valid,
	output lac_pkg::lac_pix_t out_pix
);
	import lac_pkg::*;

	localparam int AW = $clog2(DEPTH);

	lac_pix_t     buf_q [DEPTH];
	logic [AW:0]  wr_ptr_q;
	logic [AW:0]  rd_ptr_q;
	logic [AW:0]  occ_q;
	logic         pop;

	assign out_valid = (wr_ptr_q != rd_ptr_q);
	assign out_pix   = buf_q[rd_ptr_q[AW-1:0]];
	assign pop       = out_valid && !out_stall;
	assign full      = (occ_q == (AW + 1)'(DEPTH));

	// Store a finished pixel
	always_ff @(posedge clk) begin
		if (wr_en) begin
			buf_q[wr_ptr_q[AW-1:0]] <= wr_pix;
		end
	end

	// Advance pointers; count slots reserved by pixels still in flight or buffered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			occ_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + (AW + 1)'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + (AW + 1)'(1);
			end
			unique case ({reserve, pop})
				2'b10:   occ_q <= occ_q + (AW + 1)'(1);
				2'b01:   occ_q <= occ_q - (AW + 1)'(1);
				default: occ_q <= occ_q;
			endcase
		end
	end

endmodule

>>> src/layer_alpha_compositor.sv
// Top level of the layer alpha compositor: coverage stage, three channel lanes, output buffer.
//
// Usage: layers of one output pixel stream in front first, one RGBA sample per
// beat on the input channel (in_valid/in_stall); the beat with last_layer high
// is the background, whose alpha is taken as opaque, and it closes the pixel.
// Absent layers (layer_present low) add nothing, and once coverage is used up
// later layers of that pixel add nothing either.
// Each closed pixel leaves as one beat on the output channel (out_valid/out_stall)
// carrying pixel_red, pixel_green and pixel_blue.
// Throughput: one layer beat per cycle while in_stall is low, with no gaps between pixels.
// After its background beat is accepted, a pixel passes the coverage stage,
// multiply, divide by 2^CHANNEL_BITS-1 and accumulate before it can be taken.
// The output buffer holds LAC_OUT_DEPTH pixels; in_stall rises when that many
// pixels are buffered or in flight, so a stalled receiver throttles the input
// only once every buffer slot is spoken for. out_valid never waits on out_stall.
// Reset clears the pipeline and the buffer, and starts a fresh pixel with full
// coverage and zero sums.
module layer_alpha_compositor #(
	parameter int CHANNEL_BITS = lac_pkg::LAC_CHANNEL_BITS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] layer_red,
	input  logic [7:0] layer_green,
	input  logic [7:0] layer_blue,
	input  logic [7:0] layer_alpha,
	input  logic       layer_present,
	input  logic       last_layer,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] pixel_red,
	output logic [7:0] pixel_green,
	output logic [7:0] pixel_blue
);
	import lac_pkg::*;

	localparam int CB = CHANNEL_BITS;

	logic          accept;
	logic          full;
	lac_ctl_t      ctl_s1;
	lac_ctl_t      ctl_s3;
	logic [CB-1:0] cov_s1;
	logic [CB-1:0] red_s1;
	logic [CB-1:0] green_s1;
	logic [CB-1:0] blue_s1;
	logic [CB-1:0] red_res;
	logic [CB-1:0] green_res;
	logic [CB-1:0] blue_res;
	lac_pix_t      wr_pix;
	lac_pix_t      out_pix;

	// Take a beat unless every buffer slot is spoken for
	assign in_stall = full;
	assign accept   = in_valid && !in_stall;

	lac_cover #(
		.CB (CB)
	) u_cover (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.layer_red     (layer_red),
		.layer_green   (layer_green),
		.layer_blue    (layer_blue),
		.layer_alpha   (layer_alpha),
		.layer_present (layer_present),
		.last_layer    (last_layer),
		.ctl_s1        (ctl_s1),
		.cov_s1        (cov_s1),
		.red_s1        (red_s1),
		.green_s1      (green_s1),
		.blue_s1       (blue_s1)
	);

	lac_lane #(
		.CB (CB)
	) u_lane_red (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl_s1 (ctl_s1),
		.cov_s1 (cov_s1),
		.ch_s1  (red_s1),
		.ctl_s3 (ctl_s3),
		.res    (red_res)
	);

	lac_lane #(
		.CB (CB)
	) u_lane_green (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl_s1 (ctl_s1),
		.cov_s1 (cov_s1),
		.ch_s1  (green_s1),
		.ctl_s3 (),
		.res    (green_res)
	);

	lac_lane #(
		.CB (CB)
	) u_lane_blue (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl_s1 (ctl_s1),
		.cov_s1 (cov_s1),
		.ch_s1  (blue_s1),
		.ctl_s3 (),
		.res    (blue_res)
	);

	// Merge the three lane sums into one 8-bit pixel
	always_comb begin
		wr_pix.red   = 8'(red_res);
		wr_pix.green = 8'(green_res);
		wr_pix.blue  = 8'(blue_res);
	end

	lac_out #(
		.DEPTH (LAC_OUT_DEPTH)
	) u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.reserve   (accept && last_layer),
		.wr_en     (ctl_s3.valid && ctl_s3.last),
		.wr_pix    (wr_pix),
		.out_stall (out_stall),
		.full      (full),
		.out_valid (out_valid),
		.out_pix   (out_pix)
	);

	assign pixel_red   = out_pix.red;
	assign pixel_green = out_pix.green;
	assign pixel_blue  = out_pix.blue;

endmodule

>>> src/lac_checker.sv
// Port-level checker for the layer alpha compositor, bound to the top level.
module lac_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       last_layer,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] pixel_red,
	input logic [7:0] pixel_green,
	input logic [7:0] pixel_blue
);
	logic [4:0] pending_q;
	logic       in_end;
	logic       out_beat;

	assign in_end   = in_valid && !in_stall && last_layer;
	assign out_beat = out_valid && !out_stall;

	// Count pixels closed at the input and not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_end && !out_beat) begin
			pending_q <= pending_q + 5'd1;
		end else if (out_beat && !in_end) begin
			pending_q <= pending_q - 5'd1;
		end
	end

	// A stalled output beat stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("out_valid dropped while stalled");

	// A stalled output beat keeps its pixel
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=>
			$stable(pixel_red) && $stable(pixel_green) && $stable(pixel_blue))
		else $error("pixel changed while stalled");

	// No pixel leaves without a background beat behind it
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 5'd0)
		else $error("output beat with no closed pixel");

	// Input stalls only while closed pixels are waiting
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> pending_q != 5'd0)
		else $error("input stalled with nothing pending");

endmodule

bind layer_alpha_compositor lac_checker u_lac_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.last_layer  (last_layer),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.pixel_red   (pixel_red),
	.pixel_green (pixel_green),
	.pixel_blue  (pixel_blue)
);

>>> bench/layer_alpha_compositor_tb.sv
// Self-checking testbench for the layer alpha compositor: directed, random and back-pressure runs.
module layer_alpha_compositor_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import lac_pkg::*;

	localparam int          CH_BITS       = LAC_CHANNEL_BITS;
	localparam int unsigned CH_FULL       = (1 << CH_BITS) - 1;
	localparam int          QUIET_LIMIT   = 4000;
	localparam int          SETTLE_CYCLES = 16;
	localparam int          MAX_REPORTS   = 10;
	localparam int          HOLD_CYCLES   = 300;

	// One layer sample as it travels on the input channel
	typedef struct {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       present;
		logic       last;
	} layer_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] layer_red;
	logic [7:0] layer_green;
	logic [7:0] layer_blue;
	logic [7:0] layer_alpha;
	logic       layer_present;
	logic       last_layer;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] pixel_red;
	logic [7:0] pixel_green;
	logic [7:0] pixel_blue;

	// Running pixel state of the predictor
	int unsigned cov_left;
	int unsigned mix_red;
	int unsigned mix_green;
	int unsigned mix_blue;
	lac_pix_t    pending_pixels[$];

	int mismatch_count = 0;
	bit tx_idle = 1'b1;
	bit rx_idle = 1'b1;
	int hold_req = 0;

	layer_alpha_compositor #(
		.CHANNEL_BITS(CH_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.layer_red(layer_red),
		.layer_green(layer_green),
		.layer_blue(layer_blue),
		.layer_alpha(layer_alpha),
		.layer_present(layer_present),
		.last_layer(last_layer),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pixel_red(pixel_red),
		.pixel_green(pixel_green),
		.pixel_blue(pixel_blue)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Start a fresh pixel: full coverage, empty sums
	function automatic void clear_pixel();
		cov_left  = CH_FULL;
		mix_red   = 0;
		mix_green = 0;
		mix_blue  = 0;
	endfunction

	// Add floor(cov * ch / full) to a sum, saturating at full scale
	function automatic int unsigned blend_channel(int unsigned sum, int unsigned cov,
		logic [7:0] ch);
		int unsigned s;
		s = sum + (cov * (ch & CH_FULL)) / CH_FULL;
		return (s > CH_FULL) ? CH_FULL : s;
	endfunction

	// Fold one accepted layer into the pixel; the background closes it
	function automatic void composite_layer(layer_t l);
		int unsigned opacity;
		int unsigned take;
		lac_pix_t    px;
		if (l.present && cov_left != 0) begin
			opacity   = l.last ? CH_FULL : (l.alpha & CH_FULL);
			take      = (cov_left < opacity) ? cov_left : opacity;
			mix_red   = blend_channel(mix_red, take, l.red);
			mix_green = blend_channel(mix_green, take, l.green);
			mix_blue  = blend_channel(mix_blue, take, l.blue);
			cov_left  = cov_left - take;
		end
		if (l.last) begin
			px.red   = mix_red[7:0];
			px.green = mix_green[7:0];
			px.blue  = mix_blue[7:0];
			pending_pixels.push_back(px);
			clear_pixel();
		end
	endfunction

	function automatic layer_t make_layer(logic [7:0] r, logic [7:0] g, logic [7:0] b,
		logic [7:0] a, logic present, logic last);
		layer_t l;
		l.red     = r;
		l.green   = g;
		l.blue    = b;
		l.alpha   = a;
		l.present = present;
		l.last    = last;
		return l;
	endfunction

	// Random layer; opaque and fully transparent alphas come up often
	function automatic layer_t rand_layer(logic last);
		layer_t l;
		l.red   = 8'($urandom_range(0, 255));
		l.green = 8'($urandom_range(0, 255));
		l.blue  = 8'($urandom_range(0, 255));
		case ($urandom_range(0, 5))
			0: l.alpha = 8'd0;
			1: l.alpha = 8'd255;
			default: l.alpha = 8'($urandom_range(0, 255));
		endcase
		l.present = ($urandom_range(0, 4) != 0);
		l.last    = last;
		return l;
	endfunction

	// Idle length: mostly a few cycles, now and then a long one
	function automatic int pick_gap();
		if ($urandom_range(0, 15) == 0)
			return $urandom_range(8, 40);
		return $urandom_range(1, 3);
	endfunction

	function automatic void flag_error(string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("%0t ns: %s", $realtime, msg);
	endfunction

	function automatic void check_channel(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want)
			flag_error($sformatf("pixel_%s mismatch: expected %0d, got %0d", name, want, got));
	endfunction

	// Offer one layer beat, hold it until taken, then predict
	task automatic send_layer(layer_t l);
		int gap;
		gap = (tx_idle && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid      <= 1'b0;
			layer_red     <= 8'($urandom_range(0, 255));
			layer_green   <= 8'($urandom_range(0, 255));
			layer_blue    <= 8'($urandom_range(0, 255));
			layer_alpha   <= 8'($urandom_range(0, 255));
			layer_present <= 1'($urandom_range(0, 1));
			last_layer    <= 1'($urandom_range(0, 1));
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		layer_red     <= l.red;
		layer_green   <= l.green;
		layer_blue    <= l.blue;
		layer_alpha   <= l.alpha;
		layer_present <= l.present;
		last_layer    <= l.last;
		do @(posedge clk); while (in_stall);
		composite_layer(l);
	endtask

	// Extremes of the fields and each corner of the compositing rule
	task automatic test_directed();
		// background alone: alpha ignored, taken as opaque
		send_layer(make_layer(8'd255, 8'd255, 8'd255, 8'd0, 1'b1, 1'b1));
		send_layer(make_layer(8'd0, 8'd0, 8'd0, 8'd255, 1'b1, 1'b1));
		// absent background alone: empty sums
		send_layer(make_layer(8'd255, 8'd255, 8'd255, 8'd255, 1'b0, 1'b1));
		// opaque front layer uses up coverage; the rest adds nothing
		send_layer(make_layer(8'd255, 8'd0, 8'd128, 8'd255, 1'b1, 1'b0));
		send_layer(make_layer(8'd77, 8'd88, 8'd99, 8'd100, 1'b1, 1'b0));
		send_layer(make_layer(8'd1, 8'd2, 8'd3, 8'd50, 1'b1, 1'b1));
		// transparent layer and absent opaque layer, then background
		send_layer(make_layer(8'd255, 8'd255, 8'd255, 8'd0, 1'b1, 1'b0));
		send_layer(make_layer(8'd255, 8'd255, 8'd255, 8'd255, 1'b0, 1'b0));
		send_layer(make_layer(8'd10, 8'd20, 8'd30, 8'd0, 1'b1, 1'b1));
		// second layer clipped to what is left, background missing
		send_layer(make_layer(8'd255, 8'd255, 8'd255, 8'd128, 1'b1, 1'b0));
		send_layer(make_layer(8'd1, 8'd2, 8'd3, 8'd200, 1'b1, 1'b0));
		send_layer(make_layer(8'd255, 8'd255, 8'd255, 8'd255, 1'b0, 1'b1));
		// thinnest and nearly opaque layers
		send_layer(make_layer(8'd255, 8'd255, 8'd255, 8'd1, 1'b1, 1'b0));
		send_layer(make_layer(8'd255, 8'd255, 8'd255, 8'd254, 1'b1, 1'b0));
		send_layer(make_layer(8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1));
		// partial layer over a present background
		send_layer(make_layer(8'd200, 8'd100, 8'd50, 8'd85, 1'b1, 1'b0));
		send_layer(make_layer(8'd85, 8'd170, 8'd255, 8'd170, 1'b1, 1'b1));
	endtask

	// Pixels of random depth and content, idling switched on and off
	task automatic test_random_pixels(int n_items);
		int sent;
		int depth;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 11) == 0) begin
				tx_idle = ($urandom_range(0, 2) != 0);
				rx_idle = ($urandom_range(0, 2) != 0);
			end
			depth = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 20) : $urandom_range(1, 4);
			for (int k = 0; k < depth; k++)
				send_layer(rand_layer(k == depth - 1));
			sent += depth;
		end
		tx_idle = 1'b1;
		rx_idle = 1'b1;
	endtask

	// Receiver holds off while short pixels stream in back to back
	task automatic test_output_backpressure();
		int depth;
		tx_idle  = 1'b0;
		rx_idle  = 1'b0;
		hold_req = HOLD_CYCLES;
		for (int p = 0; p < 60; p++) begin
			depth = $urandom_range(1, 2);
			for (int k = 0; k < depth; k++)
				send_layer(rand_layer(k == depth - 1));
		end
		tx_idle = 1'b1;
		rx_idle = 1'b1;
	endtask

	initial begin
		in_valid      <= 1'b0;
		layer_red     <= 8'd0;
		layer_green   <= 8'd0;
		layer_blue    <= 8'd0;
		layer_alpha   <= 8'd0;
		layer_present <= 1'b0;
		last_layer    <= 1'b0;
		arst_n        <= 1'b0;
		clear_pixel();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_pixels(350);
		test_output_backpressure();
		in_valid <= 1'b0;

		// drain outstanding pixels, then let the pipeline settle
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("layer_alpha_compositor_tb: done, clean");
		end else begin
			$display("layer_alpha_compositor_tb: done, errors");
		end
		$finish;
	end

	// Output side: random stalls, plus one long hold when asked
	initial begin : receiver
		int n;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req != 0) begin
				n        = hold_req;
				hold_req = 0;
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end else if (rx_idle && $urandom_range(0, 2) == 0) begin
				n = pick_gap();
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Compare each taken pixel beat with the oldest prediction
	always @(posedge clk) begin
		lac_pix_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_pixels.size() == 0) begin
				flag_error($sformatf("unexpected pixel beat: %0d %0d %0d",
					pixel_red, pixel_green, pixel_blue));
			end else begin
				want = pending_pixels.pop_front();
				check_channel("red", want.red, pixel_red);
				check_channel("green", want.green, pixel_green);
				check_channel("blue", want.blue, pixel_blue);
			end
		end
	end

	// End the run if neither channel moves for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("layer_alpha_compositor_tb: done, errors");
		$finish;
	end

endmodule
